@@ hdl/fsfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fsfl_pkg;

    localparam int MAX_SLOTS_DEF = 256;
    localparam int SLOTS_RESET   = 256;

    localparam int SLOT_W = 8;
    localparam int COUNT_W = 9;
    localparam int CFG_W = 9;
    localparam int STATUS_W = 2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NULL_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic                granted;
        logic [SLOT_W-1:0]   given_slot;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  in_use_count;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/fixed_slot_free_list_allocator_top.sv @@
// Fixed-slot pool allocator over a LIFO linked free list held in one RAM.
// Input channel (i_in_valid / o_in_stall): action 0 allocates the head slot,
// action 1 pushes i_slot_index back as the new head (null, out-of-range or
// nothing-in-use frees are ignored and reported in o_status).
// Output channel (o_out_valid / i_out_stall): one result item per input item,
// in order, from an output register.
// The accepted item is registered, its result is formed in S_EXEC and then held
// in the output register. One item is taken at a time: the head's link is read
// from the link RAM while in S_IDLE, then S_EXEC updates head, count and RAM.
// A new item is accepted while a result waits; it completes once the output
// register frees up, so a stalled receiver holds the input stalled behind it.
// Reset (synchronous, active low) and each i_cfg_we write relink slots
// 0..N-1 in order, one RAM entry per cycle, with o_in_stall high (N after
// reset = min(256, MAX_SLOTS); writes of 0 count as 1, above MAX_SLOTS as MAX_SLOTS).
// The user must write configuration only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module fixed_slot_free_list_allocator_top #(
    parameter int MAX_SLOTS = fsfl_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fsfl_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic [fsfl_pkg::SLOT_W-1:0]        i_slot_index,
    input  wire logic                               i_slot_is_null,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_granted,
    output logic      [fsfl_pkg::SLOT_W-1:0]        o_given_slot,
    output logic      [fsfl_pkg::STATUS_W-1:0]      o_status,
    output logic      [fsfl_pkg::COUNT_W-1:0]       o_in_use_count
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int LINK_W = $clog2(MAX_SLOTS + 1);
    localparam int WIDE_W = (LINK_W > fsfl_pkg::CFG_W) ? LINK_W : fsfl_pkg::CFG_W;

    logic [WIDE_W-1:0]  cfg_wide;
    logic [WIDE_W-1:0]  cfg_clamped;
    logic [IDX_W-1:0]   ram_raddr;
    logic [LINK_W-1:0]  ram_rdata;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [LINK_W-1:0]  ram_wdata;
    logic               res_valid;
    logic               res_ready;
    fsfl_pkg::t_result  res;

    logic               r_out_valid;
    fsfl_pkg::t_result  r_out;

    assign cfg_wide = WIDE_W'(i_cfg_data);

    always_comb begin
        cfg_clamped = cfg_wide;
        if (cfg_wide == '0) begin
            cfg_clamped = WIDE_W'(1);
        end else if (cfg_wide > WIDE_W'(MAX_SLOTS)) begin
            cfg_clamped = WIDE_W'(MAX_SLOTS);
        end
    end

    fsfl_link_ram #(
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (LINK_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fsfl_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .IDX_W     (IDX_W),
        .LINK_W    (LINK_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_slots    (cfg_clamped[LINK_W-1:0]),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_slot_index   (i_slot_index),
        .i_slot_is_null (i_slot_is_null),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_out.granted;
    assign o_given_slot   = r_out.given_slot;
    assign o_status       = r_out.status;
    assign o_in_use_count = r_out.in_use_count;

`ifndef ASSERT_OFF
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |-> (o_status == fsfl_pkg::ST_OK))
        else $error("granted item with non-ok status");

    a_given_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_given_slot == '0))
        else $error("slot given without a grant");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (WIDE_W'(o_in_use_count) <= WIDE_W'(MAX_SLOTS)))
        else $error("in-use count above pool size");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("pending result dropped while output full");
`endif

endmodule

`default_nettype wire

@@ hdl/fsfl_link_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fsfl_link_ram #(
    parameter int DEPTH  = fsfl_pkg::MAX_SLOTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/fsfl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fsfl_ctrl #(
    parameter int MAX_SLOTS = fsfl_pkg::MAX_SLOTS_DEF,
    parameter int IDX_W     = $clog2(MAX_SLOTS),
    parameter int LINK_W    = $clog2(MAX_SLOTS + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [LINK_W-1:0]              i_cfg_slots,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_action,
    input  wire logic [fsfl_pkg::SLOT_W-1:0]    i_slot_index,
    input  wire logic                           i_slot_is_null,
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output fsfl_pkg::t_result                   o_res,
    output logic      [IDX_W-1:0]               o_ram_raddr,
    input  wire logic [LINK_W-1:0]              i_ram_rdata,
    output logic                                o_ram_we,
    output logic      [IDX_W-1:0]               o_ram_waddr,
    output logic      [LINK_W-1:0]              o_ram_wdata
);

    localparam int WIDE_W = (LINK_W > fsfl_pkg::COUNT_W) ? LINK_W : fsfl_pkg::COUNT_W;
    localparam int SLOTS_INIT = (MAX_SLOTS < fsfl_pkg::SLOTS_RESET) ?
                                MAX_SLOTS : fsfl_pkg::SLOTS_RESET;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        S_BUILD,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state              r_state, n_state;
    logic [LINK_W-1:0]   r_slots, n_slots;
    logic [LINK_W-1:0]   r_head, n_head;
    logic [LINK_W-1:0]   r_count, n_count;
    logic [LINK_W-1:0]   r_build_pos, n_build_pos;
    logic                r_action, n_action;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_null, n_null;
    logic                r_idx_ok, n_idx_ok;

    logic [WIDE_W-1:0]   idx_wide;
    logic [WIDE_W-1:0]   head_wide;
    logic [WIDE_W-1:0]   count_wide;
    logic [LINK_W-1:0]   build_next;
    logic                head_null;
    logic                accept;
    fsfl_pkg::t_result   res;

    assign head_null = (r_head == LINK_NULL);
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign idx_wide  = WIDE_W'(i_slot_index);
    assign build_next = r_build_pos + LINK_W'(1);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_ram_raddr = head_null ? '0 : r_head[IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_slots     = r_slots;
        n_head      = r_head;
        n_count     = r_count;
        n_build_pos = r_build_pos;
        n_action    = r_action;
        n_idx       = r_idx;
        n_null      = r_null;
        n_idx_ok    = r_idx_ok;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = r_head;
        o_res_valid = 1'b0;
        res.granted    = 1'b0;
        res.given_slot = '0;
        res.status     = fsfl_pkg::ST_OK;
        res.in_use_count = '0;

        unique case (r_state)
            S_BUILD: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_build_pos[IDX_W-1:0];
                o_ram_wdata = (build_next < r_slots) ? build_next : LINK_NULL;
                n_build_pos = build_next;
                if (build_next >= r_slots) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_idx    = idx_wide[IDX_W-1:0];
                    n_null   = i_slot_is_null;
                    n_idx_ok = (idx_wide < WIDE_W'(r_slots));
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                o_res_valid = 1'b1;
                if (r_action == fsfl_pkg::ACT_ALLOC) begin
                    if (head_null) begin
                        res.status = fsfl_pkg::ST_EMPTY;
                    end else begin
                        res.granted    = 1'b1;
                        res.given_slot = head_wide[fsfl_pkg::SLOT_W-1:0];
                        if (i_res_ready) begin
                            n_head = i_ram_rdata;
                            if (r_count < LINK_NULL) begin
                                n_count = r_count + LINK_W'(1);
                            end
                        end
                    end
                end else if (r_null) begin
                    res.status = fsfl_pkg::ST_NULL_FREE;
                end else if (!r_idx_ok || (r_count == '0)) begin
                    res.status = fsfl_pkg::ST_BAD_FREE;
                end else begin
                    res.granted = 1'b1;
                    if (i_res_ready) begin
                        o_ram_we = 1'b1;
                        n_head   = LINK_W'(r_idx);
                        n_count  = r_count - LINK_W'(1);
                    end
                end
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_slots     = i_cfg_slots;
            n_head      = '0;
            n_count     = '0;
            n_build_pos = '0;
            n_state     = S_BUILD;
        end
    end

    assign head_wide  = WIDE_W'(r_head);
    assign count_wide = WIDE_W'(n_count);

    always_comb begin
        o_res              = res;
        o_res.in_use_count = count_wide[fsfl_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BUILD;
            r_slots     <= LINK_W'(SLOTS_INIT);
            r_head      <= '0;
            r_count     <= '0;
            r_build_pos <= '0;
        end else begin
            r_state     <= n_state;
            r_slots     <= n_slots;
            r_head      <= n_head;
            r_count     <= n_count;
            r_build_pos <= n_build_pos;
        end
        r_action <= n_action;
        r_idx    <= n_idx;
        r_null   <= n_null;
        r_idx_ok <= n_idx_ok;
    end

endmodule

`default_nettype wire
